[hdl/vis_pkg.sv]
// Shared types and constants for the visit idleness statistics unit
`timescale 1ns / 1ps
`default_nettype none
package vis_pkg;

    localparam int MAX_NODES_DEF = 256;
    localparam int NUM_NODES_W   = 9;
    localparam int NODE_W        = 8;
    localparam int TIME_W        = 32;
    localparam int IDL_W         = 24;
    localparam int CNT_W         = 16;
    localparam int SUM_W         = 40;
    localparam int SQ_W          = 64;
    localparam int PROD_W        = 2 * IDL_W;
    localparam int DIV_STEPS     = 64;
    localparam int ROOT_STEPS    = 24;
    localparam int MIN_IDX_W     = 7;

    localparam logic [IDL_W-1:0]       IDL_MAX       = '1;
    localparam logic [CNT_W-1:0]       CNT_MAX       = '1;
    localparam logic [IDL_W-1:0]       MIN_UNSET_MS  = 24'd100;
    localparam logic [NUM_NODES_W-1:0] NUM_NODES_RST = 9'd256;
    localparam logic [PROD_W-1:0]      ROOT_BIT_INIT = 48'h4000_0000_0000;

    typedef struct packed {
        logic                visited;
        logic [TIME_W-1:0]   last;
        logic [CNT_W-1:0]    cnt;
        logic [SUM_W-1:0]    sum;
        logic [SQ_W-1:0]     sq;
    } entry_t;

    typedef struct packed {
        logic clr_wr;
        logic load_in;
        logic rd_node;
        logic upd;
        logic wr_node;
        logic scan_init;
        logic scan_rd;
        logic div_start;
        logic div_sel_sq;
        logic div_step;
        logic mean_save;
        logic mul_mean;
        logic root_start;
        logic root_step;
        logic fin_load;
    } cmd_t;

    typedef struct packed {
        logic node_ok;
        logic counted;
    } stat_t;

    function automatic int idx_w(input int n);
        int w;
        begin
            w = $clog2(n + 1);
            idx_w = (w > MIN_IDX_W) ? w : MIN_IDX_W;
        end
    endfunction

endpackage
`default_nettype wire

[hdl/vis_ctrl.sv]
// Sequencer for node update, scans, division and square root
`timescale 1ns / 1ps
`default_nettype none
module vis_ctrl #(
    parameter int MAX_NODES = vis_pkg::MAX_NODES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    input  wire logic                               num_nodes_we,
    input  wire logic [vis_pkg::NUM_NODES_W-1:0]    num_nodes,
    input  vis_pkg::stat_t                          stat,
    output vis_pkg::cmd_t                           cmd,
    output logic [vis_pkg::idx_w(MAX_NODES)-1:0]    idx
);
    import vis_pkg::*;

    localparam int CW = idx_w(MAX_NODES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_UPD, S_WR, S_SCAN, S_DSUM_LD, S_DSUM,
        S_DSQ_LD, S_DSQ, S_MSQ, S_ROOT_LD, S_ROOT, S_FIN
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [NUM_NODES_W-1:0] num_nodes_reg, num_nodes_next;
    logic [CW-1:0]          scan;

    assign scan = (int'(num_nodes_reg) < MAX_NODES) ? CW'(num_nodes_reg) : CW'(MAX_NODES);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign idx       = cnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg & ~out_ready;
        num_nodes_next = num_nodes_we ? num_nodes : num_nodes_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (cnt_reg == CW'(MAX_NODES - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd_node = 1'b1;
                state_next  = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.wr_node   = 1'b1;
                cmd.scan_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                if (cnt_reg < scan)
                begin
                    cmd.scan_rd = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = stat.counted ? S_DSUM_LD : S_FIN;
                end
            end
            S_DSUM_LD:
            begin
                cmd.div_start = 1'b1;
                cnt_next      = '0;
                state_next    = S_DSUM;
            end
            S_DSUM:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_STEPS - 1))
                begin
                    state_next = S_DSQ_LD;
                end
            end
            S_DSQ_LD:
            begin
                cmd.mean_save  = 1'b1;
                cmd.div_start  = 1'b1;
                cmd.div_sel_sq = 1'b1;
                cnt_next       = '0;
                state_next     = S_DSQ;
            end
            S_DSQ:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_STEPS - 1))
                begin
                    state_next = S_MSQ;
                end
            end
            S_MSQ:
            begin
                cmd.mul_mean = 1'b1;
                state_next   = S_ROOT_LD;
            end
            S_ROOT_LD:
            begin
                cmd.root_start = 1'b1;
                cnt_next       = '0;
                state_next     = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CW'(ROOT_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.fin_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            num_nodes_reg <= NUM_NODES_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            num_nodes_reg <= num_nodes_next;
        end
    end

endmodule
`default_nettype wire

[hdl/vis_datapath.sv]
// Node memory, scan accumulators, divider, square root and result registers
`timescale 1ns / 1ps
`default_nettype none
module vis_datapath #(
    parameter int MAX_NODES = vis_pkg::MAX_NODES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  vis_pkg::cmd_t                           cmd,
    input  wire logic [vis_pkg::idx_w(MAX_NODES)-1:0] idx,
    output vis_pkg::stat_t                          stat,
    input  wire logic [vis_pkg::NODE_W-1:0]         node,
    input  wire logic [vis_pkg::TIME_W-1:0]         visit_time,
    output logic                                    visit_counted,
    output logic [vis_pkg::IDL_W-1:0]               idleness_ms,
    output logic [vis_pkg::IDL_W-1:0]               node_mean_ms,
    output logic [vis_pkg::IDL_W-1:0]               node_stddev_ms,
    output logic [vis_pkg::IDL_W-1:0]               global_min_ms,
    output logic [vis_pkg::IDL_W-1:0]               global_max_ms,
    output logic [vis_pkg::CNT_W-1:0]               complete_cycles,
    output logic [vis_pkg::NODE_W-1:0]              stalest_node,
    output logic [vis_pkg::TIME_W-1:0]              stalest_idleness_ms,
    output logic                                    stalest_valid
);
    import vis_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    entry_t             mem [MAX_NODES];
    entry_t             rd_reg;
    logic [AW-1:0]      addr;
    logic [AW-1:0]      node_addr;
    logic               rd_en;
    logic               wr_en;
    entry_t             wr_data;

    logic [NODE_W-1:0]  node_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               node_ok;
    logic               counted_reg;
    logic [IDL_W-1:0]   idl_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TIME_W-1:0]  old_last_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [SUM_W-1:0]   sum_new_reg;
    logic [SQ_W-1:0]    sq_new_reg;
    logic [IDL_W-1:0]   min_reg, max_reg;

    logic               scan_vld_reg;
    logic [AW-1:0]      scan_idx_reg;
    logic [TIME_W-1:0]  hidl_reg;
    logic [NODE_W-1:0]  hnode_reg;
    logic               hvalid_reg;
    logic [CNT_W-1:0]   cyc_reg;

    logic [SQ_W-1:0]    dvd_reg;
    logic [CNT_W:0]     rem_reg;
    logic [IDL_W-1:0]   mean_reg;
    logic [PROD_W-1:0]  q_reg;
    logic [PROD_W-1:0]  mm_reg;
    logic [PROD_W-1:0]  v_reg, res_reg, bit_reg;

    logic [TIME_W-1:0]  diff;
    logic [IDL_W-1:0]   idl;
    logic               cnt_sat;
    logic [TIME_W-1:0]  scan_last;
    logic [CNT_W:0]     rem_try;
    logic [PROD_W-1:0]  root_try;

    assign node_addr = AW'(node_reg);
    assign node_ok   = int'(node_reg) < MAX_NODES;
    assign stat.node_ok = node_ok;
    assign stat.counted = counted_reg;

    assign addr  = (cmd.rd_node || cmd.wr_node) ? node_addr : idx[AW-1:0];
    assign rd_en = cmd.rd_node | cmd.scan_rd;
    assign wr_en = cmd.clr_wr | (cmd.wr_node & node_ok);

    assign cnt_sat = (rd_reg.cnt == CNT_MAX);
    always_comb
    begin
        wr_data         = rd_reg;
        wr_data.visited = 1'b1;
        wr_data.last    = now_reg;
        if (counted_reg && !cnt_sat)
        begin
            wr_data.cnt = rd_reg.cnt + 1'b1;
            wr_data.sum = rd_reg.sum + SUM_W'(idl_reg);
            wr_data.sq  = rd_reg.sq + SQ_W'(prod_reg);
        end
        if (cmd.clr_wr)
        begin
            wr_data = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[addr];
        end
    end

    assign diff = (now_reg > rd_reg.last) ? (now_reg - rd_reg.last) : '0;
    assign idl  = (diff > TIME_W'(IDL_MAX)) ? IDL_MAX : diff[IDL_W-1:0];

    assign scan_last = (node_ok && scan_idx_reg == node_addr) ? old_last_reg : rd_reg.last;
    assign rem_try   = {rem_reg[CNT_W-1:0], dvd_reg[SQ_W-1]};
    assign root_try  = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counted_reg  <= 1'b0;
            min_reg      <= '0;
            max_reg      <= '0;
            scan_vld_reg <= 1'b0;
        end
        else
        begin
            scan_vld_reg <= cmd.scan_rd;
            if (cmd.upd)
            begin
                counted_reg <= node_ok & rd_reg.visited;
                if (node_ok && rd_reg.visited)
                begin
                    if (idl > max_reg)
                    begin
                        max_reg <= idl;
                    end
                    if (idl < min_reg || min_reg < MIN_UNSET_MS)
                    begin
                        min_reg <= idl;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            node_reg <= node;
            now_reg  <= visit_time;
        end
        if (cmd.upd)
        begin
            idl_reg      <= (node_ok && rd_reg.visited) ? idl : '0;
            prod_reg     <= idl * idl;
            old_last_reg <= rd_reg.last;
        end
        if (cmd.wr_node)
        begin
            n_reg       <= wr_data.cnt;
            sum_new_reg <= wr_data.sum;
            sq_new_reg  <= wr_data.sq;
        end
        scan_idx_reg <= idx[AW-1:0];
        if (cmd.scan_init)
        begin
            hidl_reg   <= '0;
            hnode_reg  <= '0;
            hvalid_reg <= 1'b0;
            cyc_reg    <= CNT_MAX;
        end
        else if (scan_vld_reg)
        begin
            if (now_reg > scan_last && (now_reg - scan_last) > hidl_reg)
            begin
                hidl_reg   <= now_reg - scan_last;
                hnode_reg  <= NODE_W'(scan_idx_reg);
                hvalid_reg <= 1'b1;
            end
            if (rd_reg.visited && rd_reg.cnt < cyc_reg)
            begin
                cyc_reg <= rd_reg.cnt;
            end
        end
        if (cmd.div_start)
        begin
            dvd_reg <= cmd.div_sel_sq ? sq_new_reg : SQ_W'(sum_new_reg);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_try >= {1'b0, n_reg})
            begin
                rem_reg <= rem_try - {1'b0, n_reg};
                dvd_reg <= {dvd_reg[SQ_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_try;
                dvd_reg <= {dvd_reg[SQ_W-2:0], 1'b0};
            end
        end
        if (cmd.mean_save)
        begin
            mean_reg <= (dvd_reg > SQ_W'(IDL_MAX)) ? IDL_MAX : dvd_reg[IDL_W-1:0];
        end
        if (cmd.mul_mean)
        begin
            mm_reg <= mean_reg * mean_reg;
            q_reg  <= dvd_reg[PROD_W-1:0];
        end
        if (cmd.root_start)
        begin
            v_reg   <= (q_reg > mm_reg) ? (q_reg - mm_reg) : '0;
            res_reg <= '0;
            bit_reg <= ROOT_BIT_INIT;
        end
        else if (cmd.root_step)
        begin
            if (v_reg >= root_try)
            begin
                v_reg   <= v_reg - root_try;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.fin_load)
        begin
            visit_counted       <= counted_reg;
            idleness_ms         <= idl_reg;
            node_mean_ms        <= counted_reg ? mean_reg : '0;
            node_stddev_ms      <= counted_reg ? res_reg[IDL_W-1:0] : '0;
            global_min_ms       <= min_reg;
            global_max_ms       <= max_reg;
            complete_cycles     <= cyc_reg;
            stalest_node        <= hnode_reg;
            stalest_idleness_ms <= hidl_reg;
            stalest_valid       <= hvalid_reg;
        end
    end

endmodule
`default_nettype wire

[hdl/visit_idleness_statistics_unit.sv]
// Top level of the visit idleness statistics unit
//
//  channel   direction  handshake               payload
//  in        input      in_valid / in_ready     node, visit_time
//  out       output     out_valid / out_ready   visit_counted .. stalest_valid
//  config    input      num_nodes_we            num_nodes
//
// Each item is read, updated and written back, then scan = min(num_nodes, MAX_NODES)
// entries are swept; a counted visit also divides for the mean and mean square and
// takes a square root. The node memory sweep (one entry per cycle) and the
// one-bit-per-cycle divider take most of the time of an item.
// After reset a clearing pass over all MAX_NODES entries runs before in_ready rises.
// A finished item waits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module visit_idleness_statistics_unit #(
    parameter int MAX_NODES = vis_pkg::MAX_NODES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            num_nodes_we,
    input  wire logic [vis_pkg::NUM_NODES_W-1:0] num_nodes,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [vis_pkg::NODE_W-1:0]      node,
    input  wire logic [vis_pkg::TIME_W-1:0]      visit_time,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 visit_counted,
    output logic [vis_pkg::IDL_W-1:0]            idleness_ms,
    output logic [vis_pkg::IDL_W-1:0]            node_mean_ms,
    output logic [vis_pkg::IDL_W-1:0]            node_stddev_ms,
    output logic [vis_pkg::IDL_W-1:0]            global_min_ms,
    output logic [vis_pkg::IDL_W-1:0]            global_max_ms,
    output logic [vis_pkg::CNT_W-1:0]            complete_cycles,
    output logic [vis_pkg::NODE_W-1:0]           stalest_node,
    output logic [vis_pkg::TIME_W-1:0]           stalest_idleness_ms,
    output logic                                 stalest_valid
);
    import vis_pkg::*;

    cmd_t                           cmd;
    stat_t                          stat;
    logic [idx_w(MAX_NODES)-1:0]    idx;

    vis_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .num_nodes_we (num_nodes_we),
        .num_nodes    (num_nodes),
        .stat         (stat),
        .cmd          (cmd),
        .idx          (idx)
    );

    vis_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .idx                 (idx),
        .stat                (stat),
        .node                (node),
        .visit_time          (visit_time),
        .visit_counted       (visit_counted),
        .idleness_ms         (idleness_ms),
        .node_mean_ms        (node_mean_ms),
        .node_stddev_ms      (node_stddev_ms),
        .global_min_ms       (global_min_ms),
        .global_max_ms       (global_max_ms),
        .complete_cycles     (complete_cycles),
        .stalest_node        (stalest_node),
        .stalest_idleness_ms (stalest_idleness_ms),
        .stalest_valid       (stalest_valid)
    );

endmodule
`default_nettype wire

[hdl/vis_checker.sv]
// Port-level checks for the visit idleness statistics unit
`timescale 1ns / 1ps
`default_nettype none
module vis_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic                            visit_counted,
    input wire logic [vis_pkg::IDL_W-1:0]       idleness_ms,
    input wire logic [vis_pkg::IDL_W-1:0]       node_mean_ms,
    input wire logic [vis_pkg::IDL_W-1:0]       node_stddev_ms,
    input wire logic [vis_pkg::IDL_W-1:0]       global_max_ms,
    input wire logic [vis_pkg::NODE_W-1:0]      stalest_node,
    input wire logic [vis_pkg::TIME_W-1:0]      stalest_idleness_ms,
    input wire logic                            stalest_valid
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(idleness_ms) && $stable(global_max_ms))
        else $error("result dropped or changed while stalled");

    a_first_visit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visit_counted |->
            idleness_ms == 0 && node_mean_ms == 0 && node_stddev_ms == 0)
        else $error("first visit carries statistics");

    a_no_stale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !stalest_valid |-> stalest_node == 0 && stalest_idleness_ms == 0)
        else $error("stalest fields set without a stale node");

    a_max_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && visit_counted |-> global_max_ms >= idleness_ms)
        else $error("global maximum below counted idleness");

endmodule

bind visit_idleness_statistics_unit vis_checker u_vis_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .visit_counted       (visit_counted),
    .idleness_ms         (idleness_ms),
    .node_mean_ms        (node_mean_ms),
    .node_stddev_ms      (node_stddev_ms),
    .global_max_ms       (global_max_ms),
    .stalest_node        (stalest_node),
    .stalest_idleness_ms (stalest_idleness_ms),
    .stalest_valid       (stalest_valid)
);
`default_nettype wire

[bench/visit_idleness_statistics_unit_test.sv]
// Self-checking bench for the visit idleness statistics unit
`timescale 1ns / 1ps
`default_nettype none
module visit_idleness_statistics_unit_test;
    import vis_pkg::*;

    typedef struct {
        logic [NODE_W-1:0] node;
        logic [TIME_W-1:0] at;
    } visit_t;

    typedef struct {
        logic              counted;
        logic [IDL_W-1:0]  idl;
        logic [IDL_W-1:0]  mean;
        logic [IDL_W-1:0]  sdev;
        logic [IDL_W-1:0]  gmin;
        logic [IDL_W-1:0]  gmax;
        logic [CNT_W-1:0]  cycles;
        logic [NODE_W-1:0] snode;
        logic [TIME_W-1:0] sidl;
        logic              svalid;
    } stats_t;

    logic clk;
    logic rst_n;
    logic num_nodes_we;
    logic [NUM_NODES_W-1:0] num_nodes;
    logic in_valid;
    logic in_ready;
    logic [NODE_W-1:0] node;
    logic [TIME_W-1:0] visit_time;
    logic out_valid;
    logic out_ready;
    logic visit_counted;
    logic [IDL_W-1:0] idleness_ms;
    logic [IDL_W-1:0] node_mean_ms;
    logic [IDL_W-1:0] node_stddev_ms;
    logic [IDL_W-1:0] global_min_ms;
    logic [IDL_W-1:0] global_max_ms;
    logic [CNT_W-1:0] complete_cycles;
    logic [NODE_W-1:0] stalest_node;
    logic [TIME_W-1:0] stalest_idleness_ms;
    logic stalest_valid;

    visit_t pending_visits[$];
    stats_t expected_stats[$];

    logic              seen[MAX_NODES_DEF];
    logic [TIME_W-1:0] last_seen[MAX_NODES_DEF];
    logic [CNT_W-1:0]  visits[MAX_NODES_DEF];
    logic [SUM_W-1:0]  idl_sum[MAX_NODES_DEF];
    logic [SQ_W-1:0]   idl_sq[MAX_NODES_DEF];
    logic [IDL_W-1:0]  min_idl;
    logic [IDL_W-1:0]  max_idl;
    int unsigned       scan_len;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    logic        hold_start;
    int unsigned hold_left;
    int unsigned errors;
    int unsigned cycle_count;
    logic [TIME_W-1:0] clock_ms;

    visit_idleness_statistics_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .num_nodes_we(num_nodes_we), .num_nodes(num_nodes),
        .in_valid(in_valid), .in_ready(in_ready),
        .node(node), .visit_time(visit_time),
        .out_valid(out_valid), .out_ready(out_ready),
        .visit_counted(visit_counted), .idleness_ms(idleness_ms),
        .node_mean_ms(node_mean_ms), .node_stddev_ms(node_stddev_ms),
        .global_min_ms(global_min_ms), .global_max_ms(global_max_ms),
        .complete_cycles(complete_cycles), .stalest_node(stalest_node),
        .stalest_idleness_ms(stalest_idleness_ms), .stalest_valid(stalest_valid)
    );

    function automatic logic [SQ_W-1:0] int_sqrt(input logic [SQ_W-1:0] v);
        logic [SQ_W-1:0] res;
        logic [SQ_W-1:0] b;
        begin
            res = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > v) b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            int_sqrt = res;
        end
    endfunction

    function automatic stats_t record_visit(input logic [NODE_W-1:0] n,
                                            input logic [TIME_W-1:0] now);
        stats_t r;
        longint d;
        longint best;
        logic [TIME_W-1:0] gap;
        logic [SQ_W-1:0] m;
        logic [SQ_W-1:0] q;
        begin
            r = '{default: '0};
            best = 0;
            for (int i = 0; i < scan_len; i++)
            begin
                d = longint'(now) - longint'(last_seen[i]);
                if (d > best)
                begin
                    best = d;
                    r.snode = NODE_W'(i);
                    r.svalid = 1'b1;
                end
            end
            r.sidl = best[TIME_W-1:0];
            if (seen[n])
            begin
                gap = (now > last_seen[n]) ? now - last_seen[n] : '0;
                r.idl = (gap > IDL_MAX) ? IDL_MAX : gap[IDL_W-1:0];
                r.counted = 1'b1;
                if (r.idl > max_idl) max_idl = r.idl;
                if (r.idl < min_idl || min_idl < MIN_UNSET_MS) min_idl = r.idl;
                if (visits[n] < CNT_MAX)
                begin
                    visits[n] = visits[n] + 1'b1;
                    idl_sum[n] = idl_sum[n] + r.idl;
                    idl_sq[n] = idl_sq[n] + SQ_W'(r.idl) * SQ_W'(r.idl);
                end
                m = idl_sum[n] / visits[n];
                q = idl_sq[n] / visits[n];
                r.mean = (m > IDL_MAX) ? IDL_MAX : m[IDL_W-1:0];
                m = int_sqrt((q > m * m) ? q - m * m : '0);
                r.sdev = (m > IDL_MAX) ? IDL_MAX : m[IDL_W-1:0];
            end
            seen[n] = 1'b1;
            last_seen[n] = now;
            r.cycles = CNT_MAX;
            for (int i = 0; i < scan_len; i++)
                if (seen[i] && visits[i] < r.cycles) r.cycles = visits[i];
            r.gmin = min_idl;
            r.gmax = max_idl;
            record_visit = r;
        end
    endfunction

    task automatic queue_visit(input int unsigned n, input logic [TIME_W-1:0] at);
        visit_t v;
        begin
            v.node = NODE_W'(n);
            v.at = at;
            pending_visits.insert(pending_visits.size(), v);
        end
    endtask

    task automatic queue_random(input int count);
        int unsigned pick;
        begin
            for (int k = 0; k < count; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60) clock_ms = clock_ms + $urandom_range(0, 400);
                else if (pick < 85) clock_ms = clock_ms + $urandom_range(0, 50000);
                else if (pick < 93) clock_ms = clock_ms + $urandom_range(0, 30000000);
                else if (pick < 97) clock_ms = clock_ms - $urandom_range(0, 5000);
                else clock_ms = $urandom;
                if ($urandom_range(0, 9) == 0)
                    queue_visit($urandom_range(0, 255), clock_ms);
                else
                    queue_visit($urandom_range(0, (scan_len > 256 ? 256 : scan_len) - 1),
                                clock_ms);
            end
        end
    endtask

    task automatic drain_and_configure(input int unsigned n, input int unsigned sidle,
                                       input int unsigned rstall);
        begin
            wait (pending_visits.size() == 0 && !in_valid && expected_stats.size() == 0);
            repeat (600) @(posedge clk);
            num_nodes_we <= 1;
            num_nodes <= NUM_NODES_W'(n);
            @(posedge clk);
            num_nodes_we <= 0;
            scan_len = (n > MAX_NODES_DEF) ? MAX_NODES_DEF : n;
            send_idle_pct = sidle;
            recv_stall_pct = rstall;
        end
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 0;
        else
        begin
            if (in_valid && in_ready)
                expected_stats.insert(expected_stats.size(),
                                      record_visit(node, visit_time));
            if (!in_valid || in_ready)
            begin
                if (pending_visits.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    node <= pending_visits[0].node;
                    visit_time <= pending_visits[0].at;
                    in_valid <= 1;
                    void'(pending_visits.pop_front());
                end
                else
                    in_valid <= 0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_start)
            hold_left <= 4000;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 0;
        end
        else
        begin
            if (hold_start || hold_left != 0)
                out_ready <= 0;
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (out_valid && out_ready)
            begin
                if (expected_stats.size() == 0)
                begin
                    $error("unexpected item: no result pending");
                    errors++;
                end
                else
                begin
                    stats_t e;
                    e = expected_stats.pop_front();
                    if (visit_counted !== e.counted)
                    begin
                        $error("visit_counted exp %0d got %0d", e.counted, visit_counted);
                        errors++;
                    end
                    if (idleness_ms !== e.idl)
                    begin
                        $error("idleness_ms exp %0d got %0d", e.idl, idleness_ms);
                        errors++;
                    end
                    if (node_mean_ms !== e.mean)
                    begin
                        $error("node_mean_ms exp %0d got %0d", e.mean, node_mean_ms);
                        errors++;
                    end
                    if (node_stddev_ms !== e.sdev)
                    begin
                        $error("node_stddev_ms exp %0d got %0d", e.sdev, node_stddev_ms);
                        errors++;
                    end
                    if (global_min_ms !== e.gmin)
                    begin
                        $error("global_min_ms exp %0d got %0d", e.gmin, global_min_ms);
                        errors++;
                    end
                    if (global_max_ms !== e.gmax)
                    begin
                        $error("global_max_ms exp %0d got %0d", e.gmax, global_max_ms);
                        errors++;
                    end
                    if (complete_cycles !== e.cycles)
                    begin
                        $error("complete_cycles exp %0d got %0d", e.cycles, complete_cycles);
                        errors++;
                    end
                    if (stalest_node !== e.snode)
                    begin
                        $error("stalest_node exp %0d got %0d", e.snode, stalest_node);
                        errors++;
                    end
                    if (stalest_idleness_ms !== e.sidl)
                    begin
                        $error("stalest_idleness_ms exp %0d got %0d", e.sidl,
                               stalest_idleness_ms);
                        errors++;
                    end
                    if (stalest_valid !== e.svalid)
                    begin
                        $error("stalest_valid exp %0d got %0d", e.svalid, stalest_valid);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4000000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 0;
        num_nodes_we = 0;
        num_nodes = NUM_NODES_RST;
        node = 0;
        visit_time = 0;
        hold_start = 0;
        errors = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        clock_ms = 0;
        scan_len = MAX_NODES_DEF;
        min_idl = 0;
        max_idl = 0;
        for (int i = 0; i < MAX_NODES_DEF; i++)
        begin
            seen[i] = 0;
            last_seen[i] = 0;
            visits[i] = 0;
            idl_sum[i] = 0;
            idl_sq[i] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1;

        drain_and_configure(256, 0, 0);
        queue_visit(0, 0);
        queue_visit(0, 0);
        queue_visit(255, 50);
        queue_visit(0, 80);
        queue_visit(255, 60);
        queue_visit(0, 1000);
        queue_visit(0, 900);
        queue_visit(255, 32'h0200_0000);
        queue_visit(170, 32'h0200_0010);
        queue_visit(85, 32'hFFFF_FFFF);
        queue_visit(85, 32'hFFFF_FFFF);
        queue_visit(170, 32'hFFFF_FFF0);
        queue_visit(0, 32'h1000);
        queue_visit(170, 32'hAAAA_5555);
        queue_visit(85, 32'h5555_AAAA);
        queue_visit(255, 32'h5555_AAAA);
        clock_ms = 32'h5555_AAAA;

        drain_and_configure(8, 0, 0);
        queue_random(350);
        drain_and_configure(1, 59, 0);
        queue_random(200);
        drain_and_configure(4, 0, 59);
        queue_random(300);
        @(posedge clk);
        hold_start <= 1;
        @(posedge clk);
        hold_start <= 0;
        drain_and_configure(32, 7, 7);
        queue_random(300);
        drain_and_configure(300, 0, 0);
        queue_random(100);
        drain_and_configure(256, 0, 0);
        queue_random(60);

        wait (pending_visits.size() == 0 && !in_valid && expected_stats.size() == 0);
        repeat (600) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
